>>> hw/rtl/iir_direct_form_one_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the direct-form I IIR filter core
// Shared wrappers for clocked, reset-qualified checks.
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_ONE_FILTER_CORE_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IIRDF1_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IIRDF1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// Direct-form I IIR filter package
// Request types, operation codes, sequencer states and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf1_pkg;

    // Default number of numerator taps.
    localparam int DEFAULT_TAPS = 5;

    // Sample and coefficient width, and the Q3.29 to Q1.15 rounding shift.
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ROUND_SHIFT = 14;

    // Operation codes of an input request.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_LOAD_A = 2'd2;

    // Input request.
    typedef struct packed {
        logic [1:0]                 op;
        logic [2:0]                 coef_index;
        logic signed [SAMPLE_W-1:0] value;
    } t_in_req;

    // Output request.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       saturated;
    } t_out_req;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/iir_direct_form_one_filter_core.sv
// A sample request is accepted only in the idle state; the sequencer then steps through MAC,
// drain and rounding, registering the result. The single shared 16x16 multiplier covers all
// 2*TAPS-1 products in turn; no new sample or coefficient load is taken until it is idle again.
// A full output register can hold the sequencer in its rounding step until the result is taken.
// Reset (synchronous, active low) clears histories, coefficients and all control state.
// ----------------------------------------------------------------------------
// Direct-form I IIR filter core
// Streaming IIR filter, a0 fixed at 1, with one shared multiply-accumulate
// unit stepped by a small sequencer; output rounded and saturated to Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iir_direct_form_one_filter_core_macros.svh"

module iir_direct_form_one_filter_core #(
    parameter int TAPS = iirdf1_pkg::DEFAULT_TAPS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire iirdf1_pkg::t_in_req  i_in_req,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output iirdf1_pkg::t_out_req      o_out_req
);
    import iirdf1_pkg::*;

    localparam int IDX_W = $clog2(TAPS);
    localparam int ACC_W = PROD_W + $clog2(2 * TAPS);

    localparam logic signed [ACC_W:0] Q_MAX = (ACC_W+1)'(32'sd32767);
    localparam logic signed [ACC_W:0] Q_MIN = (ACC_W+1)'(-32'sd32768);
    localparam logic signed [ACC_W:0] Q_BIAS = (ACC_W+1)'(32'sd8192);

    // Coefficients and histories; feedback and history entries run 1..TAPS-1.
    logic signed [SAMPLE_W-1:0] r_coef_b [TAPS];
    logic signed [SAMPLE_W-1:0] r_coef_a [1:TAPS-1];
    logic signed [SAMPLE_W-1:0] r_hist_x [1:TAPS-1];
    logic signed [SAMPLE_W-1:0] r_hist_y [1:TAPS-1];

    // Sequencer and datapath registers.
    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_tap;
    logic                       r_fb;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_vld;
    logic                       r_prod_neg;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    t_out_req                   r_out_req;

    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_mac_en;
    logic                       w_commit;
    logic                       w_last_step;
    logic [31:0]                w_idx32;
    logic [IDX_W-1:0]           w_load_idx;
    logic                       w_load_b;
    logic                       w_load_a;
    logic [IDX_W-1:0]           w_hist_idx;
    logic signed [SAMPLE_W-1:0] w_op_coef;
    logic signed [SAMPLE_W-1:0] w_op_data;
    logic signed [ACC_W:0]      w_round_t;
    logic signed [ACC_W:0]      w_round_q;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                       w_sat;

    // Handshake qualifiers.
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Coefficient load decode; the index is widened before the range check.
    assign w_idx32    = 32'(i_in_req.coef_index);
    assign w_load_idx = w_idx32[IDX_W-1:0];
    assign w_load_b   = w_in_acc && (i_in_req.op == OP_LOAD_B) && (w_idx32 < 32'(TAPS));
    assign w_load_a   = w_in_acc && (i_in_req.op == OP_LOAD_A) &&
                        (w_idx32 != 32'd0) && (w_idx32 < 32'(TAPS));

    // Final step is the feedback product of the oldest tap.
    assign w_last_step = (r_tap == IDX_W'(TAPS - 1)) && r_fb;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_req.op == OP_SAMPLE)) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (w_last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // State-decoded controls.
    always_comb begin
        o_in_stall = 1'b1;
        w_mac_en   = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_MAC:   w_mac_en   = 1'b1;
            S_DRAIN: w_mac_en   = 1'b0;
            S_ROUND: w_commit   = w_out_free;
        endcase
    end

    // Operand select: tap zero uses the new sample, later taps take a history
    // entry, with the feedback half of each later tap taken from the output history.
    assign w_hist_idx = (r_tap == '0) ? IDX_W'(1) : r_tap;

    always_comb begin
        if (r_tap == '0) begin
            w_op_coef = r_coef_b[r_tap];
            w_op_data = r_x;
        end else if (!r_fb) begin
            w_op_coef = r_coef_b[r_tap];
            w_op_data = r_hist_x[w_hist_idx];
        end else begin
            w_op_coef = r_coef_a[w_hist_idx];
            w_op_data = r_hist_y[w_hist_idx];
        end
    end

    // Round half up to Q1.15, then saturate.
    assign w_round_t = (ACC_W+1)'(r_acc) + Q_BIAS;
    assign w_round_q = w_round_t >>> ROUND_SHIFT;

    always_comb begin
        if (w_round_q > Q_MAX) begin
            w_y   = SAMPLE_W'(Q_MAX);
            w_sat = 1'b1;
        end else if (w_round_q < Q_MIN) begin
            w_y   = SAMPLE_W'(Q_MIN);
            w_sat = 1'b1;
        end else begin
            w_y   = w_round_q[SAMPLE_W-1:0];
            w_sat = 1'b0;
        end
    end

    // Control registers: state, step counter, product valid and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_fb        <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prod_vld <= w_mac_en;
            if (w_in_acc) begin
                r_tap <= '0;
                r_fb  <= 1'b0;
            end else if (w_mac_en) begin
                if (r_tap == '0) begin
                    r_tap <= IDX_W'(1);
                end else if (!r_fb) begin
                    r_fb <= 1'b1;
                end else if (!w_last_step) begin
                    r_tap <= r_tap + IDX_W'(1);
                    r_fb  <= 1'b0;
                end
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Coefficient and history storage, all cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_coef_b[i] <= '0;
            end
            for (int i = 1; i < TAPS; i++) begin
                r_coef_a[i] <= '0;
                r_hist_x[i] <= '0;
                r_hist_y[i] <= '0;
            end
        end else begin
            if (w_load_b) begin
                r_coef_b[w_load_idx] <= i_in_req.value;
            end
            if (w_load_a) begin
                r_coef_a[w_load_idx] <= i_in_req.value;
            end
            if (w_commit) begin
                r_hist_x[1] <= r_x;
                r_hist_y[1] <= w_y;
                for (int i = 2; i < TAPS; i++) begin
                    r_hist_x[i] <= r_hist_x[i-1];
                    r_hist_y[i] <= r_hist_y[i-1];
                end
            end
        end
    end

    // Shared multiply-accumulate datapath and output register.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x   <= i_in_req.value;
            r_acc <= '0;
        end else if (r_prod_vld) begin
            if (r_prod_neg) begin
                r_acc <= r_acc - ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (w_mac_en) begin
            r_prod     <= w_op_coef * w_op_data;
            r_prod_neg <= r_fb;
        end
        if (w_commit) begin
            r_out_req.out_sample <= w_y;
            r_out_req.saturated  <= w_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // Checks on the sequencer.
    `IIRDF1_ASSERT_NOW(a_prod_in_mac, i_clk, i_rst_n, r_prod_vld,
        (r_state == S_MAC) || (r_state == S_DRAIN), "product pending outside accumulation")
    `IIRDF1_ASSERT_NOW(a_tap_range, i_clk, i_rst_n, r_state == S_MAC,
        r_tap <= IDX_W'(TAPS - 1), "tap counter out of range")
    `IIRDF1_ASSERT_NEXT(a_sample_starts, i_clk, i_rst_n,
        w_in_acc && (i_in_req.op == OP_SAMPLE), r_state == S_MAC, "sample did not start MAC")
    `IIRDF1_ASSERT_NOW(a_out_from_round, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_ROUND, "result appeared outside rounding step")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Direct-form I IIR filter core testbench
// Drives coefficient loads and samples through the request channel and
// predicts each filtered sample in a scoreboard with its own copy of the
// histories and coefficients. Both channels idle at random, and the output
// side holds off long enough once to back the core up into its input.
// ----------------------------------------------------------------------------

module testbench;

    import iirdf1_pkg::*;

    localparam int TAPS = DEFAULT_TAPS;

    // Operation code that the core must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Stimulus sizes and run limits.
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned IDLE_PCT     = 38;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 4 * TAPS + 10;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_req o_out_req;

    // Idle controls shared by the sender and the receiver.
    bit in_idle_on   = 1'b1;
    bit out_idle_on  = 1'b1;
    bit hold_pending = 1'b0;

    // Scoreboard: a bit-exact filter model plus the queue of filtered samples
    // still owed by the core.
    class iir_scoreboard;
        logic signed [SAMPLE_W-1:0] b_coef [TAPS];
        logic signed [SAMPLE_W-1:0] a_coef [TAPS-1];
        logic signed [SAMPLE_W-1:0] x_hist [TAPS-1];
        logic signed [SAMPLE_W-1:0] y_hist [TAPS-1];
        t_out_req                   expected_outputs[$];
        int unsigned                error_count;

        function new();
            foreach (b_coef[k]) b_coef[k] = '0;
            foreach (a_coef[k]) a_coef[k] = '0;
            foreach (x_hist[k]) x_hist[k] = '0;
            foreach (y_hist[k]) y_hist[k] = '0;
            error_count = 0;
        endfunction

        // Run one sample through the filter and advance both histories.
        function t_out_req filter_sample(logic signed [SAMPLE_W-1:0] x);
            longint   acc;
            longint   y;
            t_out_req res;
            acc = longint'(b_coef[0]) * longint'(x);
            for (int k = 1; k < TAPS; k++) begin
                acc += longint'(b_coef[k]) * longint'(x_hist[k-1]);
                acc -= longint'(a_coef[k-1]) * longint'(y_hist[k-1]);
            end
            // Round half up from Q3.29 to Q1.15, then clip.
            y = (acc + 64'sd8192) >>> ROUND_SHIFT;
            res.saturated = 1'b0;
            if (y > 32767) begin
                y = 32767;
                res.saturated = 1'b1;
            end else if (y < -32768) begin
                y = -32768;
                res.saturated = 1'b1;
            end
            res.out_sample = y[SAMPLE_W-1:0];
            for (int k = TAPS - 2; k > 0; k--) begin
                x_hist[k] = x_hist[k-1];
                y_hist[k] = y_hist[k-1];
            end
            x_hist[0] = x;
            y_hist[0] = res.out_sample;
            return res;
        endfunction

        // Apply an accepted input request to the model.
        function void note_request(t_in_req r);
            case (r.op)
                OP_SAMPLE: begin
                    expected_outputs.push_back(filter_sample(r.value));
                end
                OP_LOAD_B: begin
                    if (r.coef_index < TAPS) b_coef[r.coef_index] = r.value;
                end
                OP_LOAD_A: begin
                    if (r.coef_index >= 1 && r.coef_index < TAPS)
                        a_coef[r.coef_index - 1] = r.value;
                end
                default: begin
                end
            endcase
        endfunction

        // Compare an accepted output request with the oldest prediction.
        function void check_result(t_out_req got);
            t_out_req exp_res;
            if (expected_outputs.size() == 0) begin
                $error("unexpected output: out_sample %0d, saturated %0b",
                       got.out_sample, got.saturated);
                error_count++;
                return;
            end
            exp_res = expected_outputs.pop_front();
            if (got.out_sample !== exp_res.out_sample) begin
                $error("out_sample mismatch: expected %0d, actual %0d",
                       exp_res.out_sample, got.out_sample);
                error_count++;
            end
            if (got.saturated !== exp_res.saturated) begin
                $error("saturated mismatch: expected %0b, actual %0b",
                       exp_res.saturated, got.saturated);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_outputs.size();
        endfunction
    endclass

    iir_scoreboard sb = new();

    iir_direct_form_one_filter_core #(
        .TAPS(TAPS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req  (o_out_req)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_in_req make_req(logic [1:0] op, logic [2:0] idx,
                                         logic [SAMPLE_W-1:0] value);
        t_in_req r;
        r.op         = op;
        r.coef_index = idx;
        r.value      = value;
        return r;
    endfunction

    // Offer one request, idling first at random, and wait until it is taken.
    task automatic send_request(input t_in_req r);
        while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    // Coefficient mix: full range, extremes, or moderate values that keep
    // the feedback from pinning the output at the rails.
    function automatic logic [SAMPLE_W-1:0] rand_coef();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom);
            1: return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
            default: return SAMPLE_W'(int'($urandom_range(8191)) - 4096);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return SAMPLE_W'(int'($urandom_range(63)) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Receiver: checks every accepted output request and drives the stall,
    // including one long hold-off that backs the core up.
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid && !i_out_stall)
                sb.check_result(o_out_req);
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= out_idle_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Main stimulus.
    initial begin : stimulus
        int unsigned sent;
        int unsigned burst;
        bit          hold_done;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero coefficients, unity gain, ignored loads and
        // the unused op, saturation both ways, and feedback from clipped
        // outputs.
        send_request(make_req(OP_SAMPLE, 3'd7, 16'h8000));
        send_request(make_req(OP_LOAD_B, 3'd0, 16'h4000));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h7FFF));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h8000));
        send_request(make_req(OP_LOAD_B, 3'd5, 16'h1234));
        send_request(make_req(OP_LOAD_B, 3'd7, 16'hFFFF));
        send_request(make_req(OP_LOAD_A, 3'd0, 16'h4000));
        send_request(make_req(OP_LOAD_A, 3'd5, 16'h7FFF));
        send_request(make_req(OP_LOAD_A, 3'd7, 16'h8000));
        send_request(make_req(OP_UNUSED, 3'd7, 16'h7FFF));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h0001));
        send_request(make_req(OP_LOAD_B, 3'd0, 16'h7FFF));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h7FFF));
        send_request(make_req(OP_LOAD_B, 3'd0, 16'h8000));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h7FFF));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h8000));
        send_request(make_req(OP_LOAD_B, 3'd1, 16'h7FFF));
        send_request(make_req(OP_LOAD_B, 3'd4, 16'h8000));
        send_request(make_req(OP_LOAD_A, 3'd1, 16'h8000));
        send_request(make_req(OP_LOAD_A, 3'd4, 16'h7FFF));
        send_request(make_req(OP_LOAD_A, 3'd2, 16'h0800));
        send_request(make_req(OP_LOAD_B, 3'd2, 16'hF800));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'hFFFF));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h0000));
        send_request(make_req(OP_SAMPLE, 3'd0, 16'h7FFF));

        // Random part: coefficient reloads followed by bursts of samples,
        // with a little noise from ignored loads and the unused op.
        sent = 0;
        hold_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            in_idle_on  = !(sent >= 200 && sent < 350);
            out_idle_on = in_idle_on;
            // Arm the long output hold-off once past the midpoint.
            if (!hold_done && sent >= 500) begin
                hold_pending = 1'b1;
                hold_done    = 1'b1;
            end
            case ($urandom_range(9))
                0, 1: begin
                    for (int k = 0; k < TAPS; k++) begin
                        send_request(make_req(OP_LOAD_B, 3'(k), rand_coef()));
                        sent++;
                    end
                    for (int k = 1; k < TAPS; k++) begin
                        send_request(make_req(OP_LOAD_A, 3'(k), rand_coef()));
                        sent++;
                    end
                end
                2: begin
                    send_request(make_req(2'($urandom_range(OP_LOAD_B, OP_LOAD_A)),
                                          3'($urandom_range(7)), rand_coef()));
                    sent++;
                end
                3: begin
                    if ($urandom_range(1) != 0)
                        send_request(make_req(OP_UNUSED, 3'($urandom),
                                              SAMPLE_W'($urandom)));
                    else
                        send_request(make_req(OP_LOAD_A, 3'd0, SAMPLE_W'($urandom)));
                end
                default: begin
                    burst = $urandom_range(4, 20);
                    repeat (burst) begin
                        send_request(make_req(OP_SAMPLE, 3'($urandom), rand_sample()));
                        sent++;
                    end
                end
            endcase
        end
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        i_in_valid <= 1'b0;

        // Drain, then give the core time to show any stray output.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/iirdf1_pkg.sv
hw/rtl/iir_direct_form_one_filter_core.sv
sim/testbench.sv
